// File: hdl/dgchs_pkg.sv
// ----------------------------------------------------------------------------
// dgchs_pkg
// Shared types and constants for the disk geometry / LBA to CHS core.
// ----------------------------------------------------------------------------
`default_nettype none

package dgchs_pkg;

	localparam int unsigned IMG_W    = 42;
	localparam int unsigned LBA_W    = 32;
	localparam int unsigned DSR_W    = 10;
	localparam int unsigned SECT_W   = 28;
	localparam int unsigned OUT_W    = 72;

	localparam logic [32:0] SECT_CAP = 33'd267382800;  // 65535*16*255
	localparam logic [27:0] SECT_BIG = 28'd66059280;   // 65535*16*63

	localparam logic [4:0]  HEADS_MIN = 5'd4;
	localparam logic [4:0]  HEADS_MAX = 5'd16;
	localparam logic [5:0]  SPT_17    = 6'd17;
	localparam logic [5:0]  SPT_31    = 6'd31;
	localparam logic [5:0]  SPT_63    = 6'd63;
	localparam logic [15:0] CYL_MAX   = 16'd65535;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_OVERLAP = 2'd1,
		STATUS_EXCEEDS = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_GEO_INIT,
		S_GEO_W17,
		S_GEO_W31,
		S_GEO_W63,
		S_GEO_CYL,
		S_GEO_WCYL,
		S_ITEM_WCYL,
		S_ITEM_WSEC,
		S_ITEM_OUT
	} state_t;

	typedef struct packed {
		logic             start;
		logic [LBA_W-1:0] dividend;
		logic [DSR_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [LBA_W-1:0] quotient;
		logic [DSR_W-1:0] remainder;
	} div_rsp_t;

endpackage

`default_nettype wire

// File: hdl/dgchs_div.sv
// ----------------------------------------------------------------------------
// dgchs_div
// Restoring divider, 32-bit dividend by 10-bit divisor, one bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dgchs_div (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire dgchs_pkg::div_req_t req,
	output dgchs_pkg::div_rsp_t      rsp
);

	localparam logic [5:0] ITER = 6'(dgchs_pkg::LBA_W);

	logic                          busy_q;
	logic                          done_q;
	logic [5:0]                    cnt_q;
	logic [dgchs_pkg::LBA_W-1:0]   quo_q;
	logic [dgchs_pkg::DSR_W-1:0]   rem_q;
	logic [dgchs_pkg::DSR_W-1:0]   dsr_q;
	logic [dgchs_pkg::DSR_W:0]     trial;
	logic [dgchs_pkg::DSR_W:0]     diff;
	logic                          ge;

	always_comb begin
		trial = {rem_q, quo_q[dgchs_pkg::LBA_W-1]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= ITER;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[dgchs_pkg::LBA_W-2:0], ge};
			rem_q <= ge ? diff[dgchs_pkg::DSR_W-1:0] : trial[dgchs_pkg::DSR_W-1:0];
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

`default_nettype wire

// File: hdl/disk_geometry_lba_to_chs_core.sv
// ----------------------------------------------------------------------------
// disk_geometry_lba_to_chs_core
// CHS geometry from the image size and LBA to CHS conversion with checks.
// ----------------------------------------------------------------------------
// A write on the cfg channel loads image_bytes and starts the geometry
// computation: a setup step, two to four serial divisions and one more
// step, during which s_axis_tready is low. The cfg channel is ready only
// while the core is idle, and a pending cfg write holds off the next LBA.
// Each LBA that converts then takes two serial divisions and one output
// step; one rejected as overlapping or beyond the image goes straight to
// the output step. All divisions run through one shared divider that
// retires one quotient bit per cycle. The result waits in an output
// register, so the next LBA is taken while it is still held; a stalled
// output register holds the core.
`default_nettype none

module disk_geometry_lba_to_chs_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [41:0] cfg_data,      // image_bytes
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // lba
	input  wire         s_axis_tuser,  // new_table
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [71:0] m_axis_tdata   // chs_head[3:0] chs_sector[9:4]
	                                   // chs_cylinder[35:10] geom_heads[40:36]
	                                   // geom_spt[46:41] geom_cylinders[62:47]
	                                   // status[64:63] zero[71:65]
);

	dgchs_pkg::state_t   state_q, state_d;
	dgchs_pkg::div_req_t div_req;
	dgchs_pkg::div_rsp_t div_rsp;

	logic [dgchs_pkg::IMG_W-1:0]  image_q;
	logic [31:0]                  prev_q;
	logic [4:0]                   heads_q;
	logic [5:0]                   spt_q;
	logic [15:0]                  gcyl_q;
	logic [31:0]                  lba_q;
	logic [dgchs_pkg::DSR_W-1:0]  per_cyl;
	logic [32:0]                  img_sect;
	logic [dgchs_pkg::SECT_W-1:0] sectors;
	logic                         big;
	logic [24:0]                  hc_sum;
	logic [14:0]                  hc;
	logic [14:0]                  h4;
	logic                         need31;
	logic                         need63;
	logic                         s_acc;
	logic                         cfg_acc;
	logic [31:0]                  floor_lba;
	logic                         overlap;
	logic                         exceeds;
	logic                         out_free;

	logic [3:0]                   head_r_q;
	logic [5:0]                   sec_r_q;
	logic [25:0]                  cyl_r_q;
	dgchs_pkg::status_t           status_r_q;

	logic [3:0]                   m_head_q;
	logic [5:0]                   m_sec_q;
	logic [25:0]                  m_cyl_q;
	logic [4:0]                   m_heads_q;
	logic [5:0]                   m_spt_q;
	logic [15:0]                  m_gcyl_q;
	dgchs_pkg::status_t           m_status_q;
	logic                         m_valid_q;

	dgchs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign cfg_ready     = (state_q == dgchs_pkg::S_IDLE);
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign s_axis_tready = (state_q == dgchs_pkg::S_IDLE) && !cfg_valid;
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	always_comb begin
		img_sect = image_q[dgchs_pkg::IMG_W-1:9];
		sectors  = (img_sect > dgchs_pkg::SECT_CAP) ? dgchs_pkg::SECT_CAP[dgchs_pkg::SECT_W-1:0]
		                                            : img_sect[dgchs_pkg::SECT_W-1:0];
		big      = sectors > dgchs_pkg::SECT_BIG;
		hc_sum   = {1'b0, div_rsp.quotient[23:0]} + 25'd1023;
		hc       = hc_sum[24:10];
		h4       = (hc < 15'(dgchs_pkg::HEADS_MIN)) ? 15'(dgchs_pkg::HEADS_MIN) : hc;
		need31   = (div_rsp.quotient >= {7'd0, h4, 10'd0}) || (h4 > 15'(dgchs_pkg::HEADS_MAX));
		need63   = div_rsp.quotient >= {17'd0, dgchs_pkg::HEADS_MAX, 10'd0};
		per_cyl  = 10'(heads_q) * 10'(spt_q);
		floor_lba = s_axis_tuser ? 32'd1 : prev_q;
		overlap  = s_axis_tdata < floor_lba;
		exceeds  = {1'b0, s_axis_tdata, 9'd0} > image_q;
	end

	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = {4'd0, sectors};
		div_req.divisor  = 10'(dgchs_pkg::SPT_17);
		unique case (state_q)
			dgchs_pkg::S_IDLE: begin
				div_req.dividend = s_axis_tdata;
				div_req.divisor  = per_cyl;
				if (s_acc) begin
					if (overlap || exceeds) begin
						state_d = dgchs_pkg::S_ITEM_OUT;
					end else begin
						div_req.start = 1'b1;
						state_d       = dgchs_pkg::S_ITEM_WCYL;
					end
				end
			end
			dgchs_pkg::S_GEO_INIT: begin
				div_req.start = 1'b1;
				if (big) begin
					div_req.divisor = 10'(dgchs_pkg::SPT_63);
					state_d         = dgchs_pkg::S_GEO_W63;
				end else begin
					state_d = dgchs_pkg::S_GEO_W17;
				end
			end
			dgchs_pkg::S_GEO_W17: begin
				div_req.divisor = 10'(dgchs_pkg::SPT_31);
				if (div_rsp.done) begin
					if (need31) begin
						div_req.start = 1'b1;
						state_d       = dgchs_pkg::S_GEO_W31;
					end else begin
						state_d = dgchs_pkg::S_GEO_CYL;
					end
				end
			end
			dgchs_pkg::S_GEO_W31: begin
				div_req.divisor = 10'(dgchs_pkg::SPT_63);
				if (div_rsp.done) begin
					if (need63) begin
						div_req.start = 1'b1;
						state_d       = dgchs_pkg::S_GEO_W63;
					end else begin
						state_d = dgchs_pkg::S_GEO_CYL;
					end
				end
			end
			dgchs_pkg::S_GEO_W63: begin
				if (div_rsp.done) begin
					state_d = dgchs_pkg::S_GEO_CYL;
				end
			end
			dgchs_pkg::S_GEO_CYL: begin
				div_req.start    = 1'b1;
				div_req.dividend = div_rsp.quotient;
				div_req.divisor  = 10'(heads_q);
				state_d          = dgchs_pkg::S_GEO_WCYL;
			end
			dgchs_pkg::S_GEO_WCYL: begin
				if (div_rsp.done) begin
					state_d = dgchs_pkg::S_IDLE;
				end
			end
			dgchs_pkg::S_ITEM_WCYL: begin
				div_req.dividend = {22'd0, div_rsp.remainder};
				div_req.divisor  = 10'(spt_q);
				if (div_rsp.done) begin
					div_req.start = 1'b1;
					state_d       = dgchs_pkg::S_ITEM_WSEC;
				end
			end
			dgchs_pkg::S_ITEM_WSEC: begin
				if (div_rsp.done) begin
					state_d = dgchs_pkg::S_ITEM_OUT;
				end
			end
			dgchs_pkg::S_ITEM_OUT: begin
				if (out_free) begin
					state_d = dgchs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dgchs_pkg::S_IDLE;
			end
		endcase
		if (cfg_acc) begin
			div_req.start = 1'b0;
			state_d       = dgchs_pkg::S_GEO_INIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dgchs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration, geometry and previous LBA
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_q <= '0;
			prev_q  <= 32'd1;
			heads_q <= dgchs_pkg::HEADS_MIN;
			spt_q   <= dgchs_pkg::SPT_17;
			gcyl_q  <= '0;
		end else begin
			if (cfg_acc) begin
				image_q <= cfg_data;
			end
			unique case (state_q)
				dgchs_pkg::S_GEO_INIT: begin
					heads_q <= big ? dgchs_pkg::HEADS_MAX : dgchs_pkg::HEADS_MIN;
					spt_q   <= big ? dgchs_pkg::SPT_63 : dgchs_pkg::SPT_17;
				end
				dgchs_pkg::S_GEO_W17: begin
					if (div_rsp.done) begin
						if (need31) begin
							heads_q <= dgchs_pkg::HEADS_MAX;
							spt_q   <= dgchs_pkg::SPT_31;
						end else begin
							heads_q <= h4[4:0];
						end
					end
				end
				dgchs_pkg::S_GEO_W31: begin
					if (div_rsp.done && need63) begin
						spt_q <= dgchs_pkg::SPT_63;
					end
				end
				dgchs_pkg::S_GEO_WCYL: begin
					if (div_rsp.done) begin
						gcyl_q <= (div_rsp.quotient > 32'(dgchs_pkg::CYL_MAX))
						          ? dgchs_pkg::CYL_MAX : div_rsp.quotient[15:0];
					end
				end
				dgchs_pkg::S_ITEM_WSEC: begin
					if (div_rsp.done) begin
						prev_q <= lba_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// per-item result
	always_ff @(posedge clk) begin
		if (s_acc) begin
			lba_q      <= s_axis_tdata;
			head_r_q   <= '0;
			sec_r_q    <= '0;
			cyl_r_q    <= '0;
			status_r_q <= overlap ? dgchs_pkg::STATUS_OVERLAP
			              : (exceeds ? dgchs_pkg::STATUS_EXCEEDS : dgchs_pkg::STATUS_OK);
		end
		if (state_q == dgchs_pkg::S_ITEM_WCYL && div_rsp.done) begin
			cyl_r_q <= div_rsp.quotient[25:0];
		end
		if (state_q == dgchs_pkg::S_ITEM_WSEC && div_rsp.done) begin
			head_r_q <= div_rsp.quotient[3:0];
			sec_r_q  <= div_rsp.remainder[5:0] + 6'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == dgchs_pkg::S_ITEM_OUT && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == dgchs_pkg::S_ITEM_OUT && out_free) begin
			m_head_q   <= head_r_q;
			m_sec_q    <= sec_r_q;
			m_cyl_q    <= cyl_r_q;
			m_heads_q  <= heads_q;
			m_spt_q    <= spt_q;
			m_gcyl_q   <= gcyl_q;
			m_status_q <= status_r_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_status_q, m_gcyl_q, m_spt_q, m_heads_q,
	                        m_cyl_q, m_sec_q, m_head_q};

endmodule

`default_nettype wire

// File: test/disk_geometry_lba_to_chs_core_test.sv
// ----------------------------------------------------------------------------
// disk_geometry_lba_to_chs_core_test
// Self-checking bench: derives the expected CHS geometry from each image size
// written on the cfg channel, converts every LBA transfer the core accepts,
// and compares each output transfer field by field in order. Directed corner
// cases come first, then random phases of ascending partition LBAs mixed with
// overlapping, out-of-range and noise LBAs, under random flow control.
// ----------------------------------------------------------------------------
module disk_geometry_lba_to_chs_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned CAP_SECT = 64'd267382800;
	localparam longint unsigned BIG_SECT = 64'd66059280;
	localparam longint unsigned IMG_MAX  = 64'd2199023255552;
	localparam longint unsigned IMG_MASK = (64'd1 << 42) - 64'd1;
	localparam int unsigned     NUM_LBAS = 1250;
	localparam int unsigned     HOLD_LEN = 400;
	localparam int unsigned     LIMIT    = 4000;

	typedef struct packed {
		logic [6:0]         pad;
		dgchs_pkg::status_t status;
		logic [15:0]        cyls;
		logic [5:0]         spt;
		logic [4:0]         heads;
		logic [25:0]        cyl;
		logic [5:0]         sector;
		logic [3:0]         head;
	} chs_word_t;

	class chs_tracker;
		longint unsigned image_bytes;
		logic [31:0]     prev_lba;
		logic [4:0]      geo_heads;
		logic [5:0]      geo_spt;
		logic [15:0]     geo_cyls;
		chs_word_t       pending_chs[$];
		int unsigned     errors;

		function new();
			prev_lba = 32'd1;
			errors = 0;
			set_image(64'd0);
		endfunction

		function void set_image(longint unsigned bytes);
			longint unsigned sec, cth, h, s, c;
			image_bytes = bytes & IMG_MASK;
			sec = image_bytes / 512;
			if (sec > CAP_SECT) begin
				sec = CAP_SECT;
			end
			if (sec > BIG_SECT) begin
				h = 16;
				s = 63;
				cth = sec / s;
			end else begin
				s = 17;
				cth = sec / s;
				h = (cth + 1023) >> 10;
				if (h < 4) begin
					h = 4;
				end
				if (cth >= (h << 10) || h > 16) begin
					s = 31;
					h = 16;
					cth = sec / s;
				end
				if (cth >= (h << 10)) begin
					s = 63;
					h = 16;
					cth = sec / s;
				end
			end
			c = cth / h;
			if (c > 65535) begin
				c = 65535;
			end
			geo_heads = 5'(h);
			geo_spt = 6'(s);
			geo_cyls = 16'(c);
		endfunction

		function void take_lba(logic [31:0] lba, logic fresh);
			chs_word_t       w;
			logic [31:0]     lba_floor;
			longint unsigned lba_bytes;
			int unsigned     per_cyl, rem, spt;
			w = '0;
			w.heads = geo_heads;
			w.spt = geo_spt;
			w.cyls = geo_cyls;
			lba_floor = fresh ? 32'd1 : prev_lba;
			lba_bytes = 64'(lba);
			lba_bytes = lba_bytes * 512;
			if (lba < lba_floor) begin
				w.status = dgchs_pkg::STATUS_OVERLAP;
			end else if (lba_bytes > image_bytes) begin
				w.status = dgchs_pkg::STATUS_EXCEEDS;
			end else begin
				spt = 32'(geo_spt);
				per_cyl = 32'(geo_heads);
				per_cyl = per_cyl * spt;
				rem = lba % per_cyl;
				w.status = dgchs_pkg::STATUS_OK;
				w.head = 4'(rem / spt);
				w.sector = 6'(rem % spt + 1);
				w.cyl = 26'(lba / per_cyl);
				prev_lba = lba;
			end
			pending_chs.push_back(w);
		endfunction

		function string show(chs_word_t w);
			return $sformatf({"head %0d sector %0d cyl %0d heads %0d spt %0d",
				" cyls %0d status %0d pad %h"},
				w.head, w.sector, w.cyl, w.heads, w.spt, w.cyls, w.status, w.pad);
		endfunction

		function void check_chs(logic [71:0] data);
			chs_word_t got, want;
			got = data;
			if (pending_chs.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected output transfer: %s", show(got));
				end
				return;
			end
			want = pending_chs.pop_front();
			if (got.head !== want.head || got.sector !== want.sector || got.cyl !== want.cyl ||
			    got.heads !== want.heads || got.spt !== want.spt || got.cyls !== want.cyls ||
			    got.status !== want.status || got.pad !== want.pad) begin
				errors++;
				if (errors <= 10) begin
					$display("CHS mismatch at %0t", $realtime);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [41:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // lba
	logic        s_axis_tuser;   // new_table
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;   // chs_head, chs_sector, chs_cylinder, geom_heads,
	                             // geom_spt, geom_cylinders, status, zero fill

	chs_tracker  tracker = new();
	bit          src_gaps;
	bit          snk_gaps;
	bit          hold_req;
	int unsigned sent;
	int unsigned idle_cycles = 0;

	disk_geometry_lba_to_chs_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
		    (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// output side: random stalls, one long hold-off on request
	initial begin
		int unsigned stall;
		m_axis_tready = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_req) begin
				stall = HOLD_LEN;
				hold_req = 1'b0;
			end else begin
				stall = snk_gaps ? $urandom_range(0, 9) : 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!(m_axis_tvalid && m_axis_tready)) @(posedge clk);
			tracker.check_chs(m_axis_tdata);
			@(negedge clk);
		end
	end

	task automatic send_lba(input logic [31:0] lba, input logic fresh);
		int unsigned gap;
		gap = src_gaps ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= lba;
		s_axis_tuser <= fresh;
		@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready)) @(posedge clk);
		tracker.take_lba(lba, fresh);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (tracker.pending_chs.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic write_image(input longint unsigned bytes);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= 42'(bytes);
		@(posedge clk);
		while (!(cfg_valid && cfg_ready)) @(posedge clk);
		tracker.set_image(bytes);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic longint unsigned pick_image();
		longint unsigned sec, img, s;
		int unsigned     kind;
		kind = $urandom_range(0, 7);
		sec = 0;
		img = 0;
		if (kind == 0) begin
			img = 64'($urandom_range(0, 65535));
		end else if (kind == 1) begin
			sec = 64'($urandom_range(1, 32'h0400_0000));
		end else if (kind <= 3) begin
			// near the heads and spt switch points
			s = ($urandom_range(0, 2) == 0) ? 17 : ($urandom_range(0, 1) ? 31 : 63);
			sec = longint'($urandom_range(1, 17)) * 1024 * s;
			sec = sec + 64'($urandom_range(0, 32'(4 * s))) - 2 * s;
		end else if (kind == 4) begin
			sec = BIG_SECT + 64'($urandom_range(0, 100)) - 50;
		end else if (kind == 5) begin
			sec = CAP_SECT + 64'($urandom_range(0, 100)) - 50;
		end else if (kind == 6) begin
			img = {$urandom, $urandom} & (IMG_MAX - 1);
		end else begin
			img = $urandom_range(0, 1) ? IMG_MAX : IMG_MAX - 64'($urandom_range(0, 4095));
		end
		if (sec != 0) begin
			img = sec * 512 + 64'($urandom_range(0, 511));
		end
		return img;
	endfunction

	task automatic pick_lba(output logic [31:0] lba, output logic fresh);
		longint unsigned top, cand;
		int unsigned     r, k;
		top = tracker.image_bytes / 512;
		if (top > 64'hFFFF_FFFF) begin
			top = 64'hFFFF_FFFF;
		end
		r = $urandom_range(0, 99);
		fresh = 1'b0;
		if (top == 0 || r < 8) begin
			lba = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom);
			fresh = 1'($urandom_range(0, 1));
		end else if (r < 14) begin
			lba = 32'(top + 64'($urandom_range(1, 3)));
			fresh = 1'($urandom_range(0, 1));
		end else if (r < 20) begin
			lba = tracker.prev_lba - $urandom_range(1, 40);
		end else begin
			cand = 64'(tracker.prev_lba);
			if ($urandom_range(0, 3) == 0) begin
				cand = cand + ({$urandom, $urandom} % (top / 16 + 1));
			end else begin
				cand = cand + 64'($urandom_range(0, 200));
			end
			if (r < 30 || cand > top) begin
				fresh = 1'b1;
				k = $urandom_range(0, 9);
				if (k == 0) begin
					cand = top;
				end else if (k < 5) begin
					cand = 1 + 64'($urandom_range(0, 100));
				end else begin
					cand = 1 + ({$urandom, $urandom} % top);
				end
				if (cand > top) begin
					cand = top;
				end
			end
			lba = 32'(cand);
		end
	endtask

	initial begin
		logic [31:0] lba;
		logic        fresh;
		int unsigned phase, count;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		src_gaps = 1'b1;
		snk_gaps = 1'b1;
		hold_req = 1'b0;
		sent = 0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty image: everything overlaps or exceeds
		send_lba(32'd0, 1'b1);
		send_lba(32'd1, 1'b1);
		write_image(64'd0);
		send_lba(32'd0, 1'b0);

		write_image(IMG_MAX);
		send_lba(32'd1, 1'b1);
		send_lba(32'hFFFF_FFFF, 1'b0);
		send_lba(32'h8000_0000, 1'b0);
		send_lba(32'd0, 1'b1);
		send_lba(32'h7FFF_FFFF, 1'b1);

		// size cap, cylinder count saturates
		write_image(CAP_SECT * 512);
		send_lba(32'd1, 1'b1);
		send_lba(32'(CAP_SECT), 1'b0);
		send_lba(32'(CAP_SECT + 1), 1'b0);

		write_image(64'd1000 * 512 + 100);
		send_lba(32'd1000, 1'b1);
		send_lba(32'd1001, 1'b0);
		send_lba(32'd999, 1'b0);
		send_lba(32'd1000, 1'b0);

		write_image(64'd511);
		send_lba(32'd1, 1'b1);

		write_image(BIG_SECT * 512);
		send_lba(32'(BIG_SECT), 1'b1);

		write_image(64'd4096 * 17 * 512);
		send_lba(32'd65535, 1'b1);

		write_image(64'd16 * 1024 * 31 * 512 + 511);
		send_lba(32'd300000, 1'b1);

		phase = 0;
		while (sent < NUM_LBAS) begin
			write_image(pick_image());
			src_gaps = $urandom_range(0, 3) != 0;
			snk_gaps = $urandom_range(0, 3) != 0;
			count = $urandom_range(20, 80);
			if (phase == 1) begin
				src_gaps = 1'b0;
				hold_req = 1'b1;
			end
			for (int unsigned i = 0; i < count; i++) begin
				pick_lba(lba, fresh);
				send_lba(lba, fresh);
				if (phase == 2 && i == count / 2) begin
					wait_idle();
				end
			end
			phase++;
		end

		wait_idle();
		repeat (300) @(negedge clk);
		if (tracker.errors == 0 && tracker.pending_chs.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
